// ===== hdl/sbph_pkg.sv =====
package sbph_pkg;

  localparam int SBPH_BANDS = 8;
  localparam int SBPH_BINS  = 512;

  localparam int IDX_W     = 9;
  localparam int SMP_W     = 32;
  localparam int LVL_W     = 16;
  localparam int BAR_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int SQ_W      = 64;
  localparam int FRAC_W    = 16;
  localparam int NORM_STEPS = 6;
  localparam int MAX_OUT   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN = 2'd1;

  localparam logic [CFG_W-1:0] FALL_STEP_RST  = 16'd3277;
  localparam logic [CFG_W-1:0] LEVEL_GAIN_RST = 16'd21845;
  localparam logic [31:0]      LN2_Q16        = 32'd45426;
  localparam logic [LVL_W-1:0] FULL_SCALE     = 16'd32768;

  localparam logic [3:0] DP_NOP   = 4'd0;
  localparam logic [3:0] DP_CAP   = 4'd1;
  localparam logic [3:0] DP_SQA   = 4'd2;
  localparam logic [3:0] DP_SQB   = 4'd3;
  localparam logic [3:0] DP_ADD   = 4'd4;
  localparam logic [3:0] DP_NORM  = 4'd5;
  localparam logic [3:0] DP_SQR   = 4'd6;
  localparam logic [3:0] DP_LN    = 4'd7;
  localparam logic [3:0] DP_GAIN  = 4'd8;
  localparam logic [3:0] DP_ACC   = 4'd9;
  localparam logic [3:0] DP_SW_WR = 4'd10;

  typedef struct packed {
    logic [3:0] step;
    logic [2:0] norm_k;
    logic       sweep;
    logic       fall;
    logic       emit;
  } sbph_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sbph_stat_t;

endpackage

// ===== hdl/sbph_ram.sv =====
module sbph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sbph_ctrl.sv =====
module sbph_ctrl #(
  parameter int BANDS = sbph_pkg::SBPH_BANDS,
  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_action,
  output logic                  in_stall,
  input  sbph_pkg::sbph_stat_t  stat,
  output sbph_pkg::sbph_cmd_t   cmd,
  output logic [BW-1:0]         k
);

  import sbph_pkg::*;

  localparam int NOUT = (BANDS < MAX_OUT) ? BANDS : MAX_OUT;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQA    = 4'd1;
  localparam logic [3:0] S_SQB    = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_NORM   = 4'd4;
  localparam logic [3:0] S_SQR    = 4'd5;
  localparam logic [3:0] S_LN     = 4'd6;
  localparam logic [3:0] S_GAIN   = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_SW_RD  = 4'd9;
  localparam logic [3:0] S_SW_UPD = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [BW-1:0] k_r, k_nxt;
  logic          fall_r, fall_nxt;
  logic          emit_k;
  logic          last_k;

  assign k = k_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    fall_nxt  = fall_r;
    emit_k    = {1'b0, k_r} < (BW+1)'(NOUT);
    last_k    = (k_r == BW'(BANDS - 1));
    in_stall  = (state_r != S_IDLE);
    cmd        = '0;
    cmd.step   = DP_NOP;
    cmd.norm_k = cnt_r[2:0];
    cmd.fall   = fall_r;
    cmd.emit   = emit_k;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            fall_nxt  = 1'b1;
            k_nxt     = '0;
            state_nxt = S_SW_RD;
          end else begin
            cmd.step  = DP_CAP;
            state_nxt = S_SQA;
          end
        end
      end
      S_SQA: begin
        cmd.step  = DP_SQA;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.step  = DP_SQB;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.step  = DP_ADD;
        cnt_nxt   = 4'(NORM_STEPS - 1);
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.step = DP_NORM;
        if (cnt_r == '0) begin
          cnt_nxt   = 4'(FRAC_W - 1);
          state_nxt = S_SQR;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      S_SQR: begin
        cmd.step = DP_SQR;
        if (cnt_r == '0) begin
          state_nxt = S_LN;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      S_LN: begin
        cmd.step  = DP_LN;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.step  = DP_GAIN;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.step = DP_ACC;
        if (stat.last) begin
          fall_nxt  = 1'b0;
          k_nxt     = '0;
          state_nxt = S_SW_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SW_RD: begin
        cmd.sweep = 1'b1;
        state_nxt = S_SW_UPD;
      end
      S_SW_UPD: begin
        cmd.sweep = 1'b1;
        if (!emit_k || stat.out_free) begin
          cmd.step = DP_SW_WR;
          if (last_k) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + BW'(1);
            state_nxt = S_SW_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      fall_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      fall_r  <= fall_nxt;
    end
  end

  a_tick_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action) |=> (state_r == S_SW_RD && fall_r))
    else $error("fall tick did not start a sweep");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == DP_SW_WR && cmd.emit) |-> stat.out_free)
    else $error("bar written over an untaken result");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= BW'(BANDS - 1))
    else $error("band counter out of range");

endmodule

// ===== hdl/sbph_dp.sv =====
module sbph_dp #(
  parameter int BANDS = sbph_pkg::SBPH_BANDS,
  parameter int BINS  = sbph_pkg::SBPH_BINS,
  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbph_pkg::sbph_cmd_t               cmd,
  input  logic [BW-1:0]                     k,
  output sbph_pkg::sbph_stat_t              stat,
  input  logic [sbph_pkg::IDX_W-1:0]        in_bin_index,
  input  logic signed [sbph_pkg::SMP_W-1:0] in_bin_real,
  input  logic signed [sbph_pkg::SMP_W-1:0] in_bin_imag,
  input  logic                              in_last_bin,
  input  logic                              cfg_valid,
  input  logic [sbph_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbph_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sbph_pkg::BAR_W-1:0]        out_band_number,
  output logic [sbph_pkg::LVL_W-1:0]        out_bar_level,
  output logic                              out_last_bar
);

  import sbph_pkg::*;

  localparam int     NOUT   = (BANDS < MAX_OUT) ? BANDS : MAX_OUT;
  localparam int     HALF   = BINS / 2;
  localparam int     P_W    = IDX_W + $clog2(2 * BANDS) + 1;
  localparam int     L_W    = $clog2(BINS);
  localparam int     SH     = P_W + L_W;
  localparam longint RECIP  = ((longint'(1) << SH) + longint'(BINS) - 1) / longint'(BINS);
  localparam int     BP_W   = 2 * P_W + 2;
  localparam logic [21:0] L2_THR = 22'(32 << FRAC_W);

  function automatic logic [SMP_W-1:0] mag(input logic signed [SMP_W-1:0] x);
    mag = x[SMP_W-1] ? (~x + 32'd1) : x;
  endfunction

  logic [SMP_W-1:0]  a_r, b_r;
  logic [BW-1:0]     band_r;
  logic              rng_r, last_r;
  logic [SQ_W-1:0]   s_r, p_r;
  logic [5:0]        sh_r;
  logic [31:0]       m_r;
  logic [FRAC_W-1:0] frac_r;
  logic [CFG_W-1:0]  fall_step_r, level_gain_r;
  logic [BANDS-1:0]  acc_vld_r, pair_vld_r;
  logic              out_vld_r, out_last_r;
  logic [BAR_W-1:0]  out_band_r;
  logic [LVL_W-1:0]  out_level_r;

  logic [P_W-1:0]    idx_p;
  logic [BP_W-1:0]   band_prod;
  logic [BP_W-1:0]   band_full;
  logic              rng_c;
  logic [31:0]       mul_a, mul_b;
  logic [SQ_W-1:0]   prod;
  logic              hz;
  logic [SQ_W-1:0]   s_sh;
  logic [5:0]        sh_inc;
  logic [32:0]       sq_q;
  logic [31:0]       m_new;
  logic [21:0]       l2;
  logic [20:0]       t;
  logic [18:0]       lvl_raw;
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  acc_rd, acc_b, acc_e;
  logic [2*LVL_W-1:0] pair_rd;
  logic [LVL_W-1:0]  frm_e, shw_e, frm_n, shw_n;
  logic              acc_we, sw_wr, out_load;
  logic [BW-1:0]     acc_raddr;

  assign idx_p     = P_W'(in_bin_index) * P_W'(2 * BANDS);
  assign band_prod = BP_W'(idx_p) * BP_W'(RECIP);
  assign band_full = band_prod >> SH;
  assign rng_c     = int'(in_bin_index) < HALF;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      DP_SQA: begin
        mul_a = a_r;
        mul_b = a_r;
      end
      DP_SQB: begin
        mul_a = b_r;
        mul_b = b_r;
      end
      DP_SQR: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      DP_LN: begin
        mul_a = 32'(t);
        mul_b = LN2_Q16;
      end
      DP_GAIN: begin
        mul_a = 32'(p_r[36:17]);
        mul_b = 32'(level_gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = SQ_W'(mul_a) * SQ_W'(mul_b);

  always_comb begin
    unique case (cmd.norm_k)
      3'd5:    hz = (s_r[63:32] == '0);
      3'd4:    hz = (s_r[63:48] == '0);
      3'd3:    hz = (s_r[63:56] == '0);
      3'd2:    hz = (s_r[63:60] == '0);
      3'd1:    hz = (s_r[63:62] == '0);
      3'd0:    hz = !s_r[63];
      default: hz = 1'b0;
    endcase
  end

  assign sh_inc = 6'd1 << cmd.norm_k;
  assign s_sh   = hz ? (s_r << (7'd1 << cmd.norm_k)) : s_r;

  assign sq_q  = prod[63:31];
  assign m_new = sq_q[32] ? sq_q[32:1] : sq_q[31:0];

  assign l2 = {~sh_r, frac_r};
  assign t  = (l2 > L2_THR) ? 21'(l2 - L2_THR) : '0;

  assign lvl_raw = p_r[35:17];
  assign lvl     = (lvl_raw > 19'(FULL_SCALE)) ? FULL_SCALE : lvl_raw[LVL_W-1:0];
  assign acc_b   = acc_vld_r[band_r] ? acc_rd : '0;
  assign acc_we  = (cmd.step == DP_ACC) && rng_r && (lvl > acc_b);

  assign acc_e = acc_vld_r[k] ? acc_rd : '0;
  assign frm_e = pair_vld_r[k] ? pair_rd[2*LVL_W-1:LVL_W] : '0;
  assign shw_e = pair_vld_r[k] ? pair_rd[LVL_W-1:0] : '0;

  always_comb begin
    if (cmd.fall) begin
      frm_n = frm_e;
      if (frm_e < shw_e) begin
        shw_n = (shw_e > fall_step_r) ? (shw_e - fall_step_r) : '0;
      end else begin
        shw_n = shw_e;
      end
    end else begin
      frm_n = acc_e;
      shw_n = (acc_e > shw_e) ? acc_e : shw_e;
    end
  end

  assign sw_wr     = (cmd.step == DP_SW_WR);
  assign out_load  = sw_wr && cmd.emit;
  assign acc_raddr = cmd.sweep ? k : band_r;

  sbph_ram #(
    .WIDTH (LVL_W),
    .DEPTH (BANDS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (band_r),
    .wdata (lvl),
    .raddr (acc_raddr),
    .rdata (acc_rd)
  );

  sbph_ram #(
    .WIDTH (2 * LVL_W),
    .DEPTH (BANDS)
  ) u_pair_ram (
    .clk   (clk),
    .we    (sw_wr),
    .waddr (k),
    .wdata ({frm_n, shw_n}),
    .raddr (k),
    .rdata (pair_rd)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      DP_CAP: begin
        a_r    <= mag(in_bin_real);
        b_r    <= mag(in_bin_imag);
        band_r <= band_full[BW-1:0];
        rng_r  <= rng_c;
        last_r <= in_last_bin;
      end
      DP_SQA: begin
        s_r <= prod;
      end
      DP_SQB: begin
        p_r <= prod;
      end
      DP_ADD: begin
        s_r  <= s_r + p_r;
        sh_r <= '0;
      end
      DP_NORM: begin
        s_r <= s_sh;
        m_r <= s_sh[63:32];
        if (hz) begin
          sh_r <= sh_r + sh_inc;
        end
      end
      DP_SQR: begin
        m_r    <= m_new;
        frac_r <= {frac_r[FRAC_W-2:0], sq_q[32]};
      end
      DP_LN, DP_GAIN: begin
        p_r <= prod;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r  <= '0;
      pair_vld_r <= '0;
    end else begin
      if (acc_we) begin
        acc_vld_r[band_r] <= 1'b1;
      end
      if (sw_wr) begin
        pair_vld_r[k] <= 1'b1;
        if (!cmd.fall) begin
          acc_vld_r[k] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_step_r  <= FALL_STEP_RST;
      level_gain_r <= LEVEL_GAIN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FALL_STEP) begin
        fall_step_r <= cfg_data;
      end else if (cfg_index == REG_LEVEL_GAIN) begin
        level_gain_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_band_r  <= BAR_W'(k);
      out_level_r <= shw_n;
      out_last_r  <= (k == BW'(NOUT - 1));
    end
  end

  assign stat.last     = last_r;
  assign stat.out_free = !out_vld_r || !out_stall;

  assign out_valid       = out_vld_r;
  assign out_band_number = out_band_r;
  assign out_bar_level   = out_level_r;
  assign out_last_bar    = out_last_r;

  a_band_map: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == DP_ACC && rng_r) |-> (band_r <= BW'(BANDS - 1)))
    else $error("bin mapped past the last band");

  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == DP_SQR) |-> (m_r[31] || m_r == '0))
    else $error("mantissa not normalized");

endmodule

// ===== hdl/spectrum_band_peak_hold_core.sv =====
// Bin transaction: two squares, a 6-step normalize, 16 log2 squaring steps and two
//   gain multiplies on one multiplier; no new bin is accepted until the transaction ends.
// Frame end or fall tick: a band sweep follows, reading and then updating each band;
//   a band update waits while an untaken bar is held at the output.
// Reset (rst_n low, synchronous) clears all band levels and bars to zero and loads
//   fall_step = 3277, level_gain = 21845.
module spectrum_band_peak_hold_core #(
  parameter int BANDS = sbph_pkg::SBPH_BANDS,
  parameter int BINS  = sbph_pkg::SBPH_BINS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [sbph_pkg::IDX_W-1:0]        in_bin_index,
  input  logic signed [sbph_pkg::SMP_W-1:0] in_bin_real,
  input  logic signed [sbph_pkg::SMP_W-1:0] in_bin_imag,
  input  logic                              in_last_bin,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sbph_pkg::BAR_W-1:0]        out_band_number,
  output logic [sbph_pkg::LVL_W-1:0]        out_bar_level,
  output logic                              out_last_bar,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbph_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbph_pkg::CFG_W-1:0]        cfg_data
);

  import sbph_pkg::*;

  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

  sbph_cmd_t     cmd;
  sbph_stat_t    stat;
  logic [BW-1:0] k;

  assign cfg_ready = 1'b1;

  sbph_ctrl #(
    .BANDS (BANDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd),
    .k         (k)
  );

  sbph_dp #(
    .BANDS (BANDS),
    .BINS  (BINS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .k               (k),
    .stat            (stat),
    .in_bin_index    (in_bin_index),
    .in_bin_real     (in_bin_real),
    .in_bin_imag     (in_bin_imag),
    .in_last_bin     (in_last_bin),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_band_number (out_band_number),
    .out_bar_level   (out_bar_level),
    .out_last_bar    (out_last_bar)
  );

endmodule

// ===== bench/tb_spectrum_band_peak_hold_core.sv =====
module tb_spectrum_band_peak_hold_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sbph_pkg::*;

  localparam logic ACT_BIN  = 1'b0;
  localparam logic ACT_FALL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int SETTLE_CYCLES = 64;
  localparam int BURST_LEN     = 500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BAR_COUNT     = (SBPH_BANDS < MAX_OUT) ? SBPH_BANDS : MAX_OUT;

  typedef struct {
    logic              action;
    logic [IDX_W-1:0]  idx;
    logic [SMP_W-1:0]  re;
    logic [SMP_W-1:0]  im;
    logic              last;
  } spec_item_t;

  typedef struct {
    logic [BAR_W-1:0] band;
    logic [LVL_W-1:0] level;
    logic             last;
  } bar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_action = 1'b0;
  logic [IDX_W-1:0]        in_bin_index = '0;
  logic signed [SMP_W-1:0] in_bin_real = '0;
  logic signed [SMP_W-1:0] in_bin_imag = '0;
  logic                    in_last_bin = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [BAR_W-1:0]        out_band_number;
  logic [LVL_W-1:0]        out_bar_level;
  logic                    out_last_bar;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  spec_item_t bins_to_send[$];
  bar_t       bars_due[$];
  spec_item_t on_wire;
  bar_t       want;

  logic [LVL_W-1:0] band_peak_run[SBPH_BANDS];
  logic [LVL_W-1:0] frame_peak[SBPH_BANDS];
  logic [LVL_W-1:0] bar_height[SBPH_BANDS];
  logic [CFG_W-1:0] fall_step_r;
  logic [CFG_W-1:0] gain_r;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;
  logic burst_on = 1'b0;
  int burst_cycles = 0;
  logic hold_out;

  spectrum_band_peak_hold_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_bin_index    (in_bin_index),
    .in_bin_real     (in_bin_real),
    .in_bin_imag     (in_bin_imag),
    .in_last_bin     (in_last_bin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_band_number (out_band_number),
    .out_bar_level   (out_bar_level),
    .out_last_bar    (out_last_bar),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [LVL_W-1:0] bin_log_level(input logic [SMP_W-1:0] re,
                                                     input logic [SMP_W-1:0] im,
                                                     input logic [CFG_W-1:0] gain);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] l2;
    logic [63:0] t;
    logic [63:0] lnq;
    logic [63:0] lvl;
    int e;
    int k;
    a = re[SMP_W-1] ? 64'h1_0000_0000 - {32'd0, re} : {32'd0, re};
    b = im[SMP_W-1] ? 64'h1_0000_0000 - {32'd0, im} : {32'd0, im};
    s = a * a + b * b;
    if (s == 64'd0) return '0;
    e = 63;
    while (!s[e]) e--;
    m = (e >= 31) ? (s >> (e - 31)) : (s << (31 - e));
    l2 = 64'(e) << 16;
    for (k = 15; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m[63:32] != 32'd0) begin
        l2[k] = 1'b1;
        m = m >> 1;
      end
    end
    if (l2 <= (64'd32 << 16)) return '0;
    t = l2 - (64'd32 << 16);
    lnq = (t * 64'(LN2_Q16)) >> 17;
    lvl = (lnq * 64'(gain)) >> 17;
    if (lvl > 64'(FULL_SCALE)) lvl = 64'(FULL_SCALE);
    return lvl[LVL_W-1:0];
  endfunction

  function automatic void emit_bars();
    bar_t r;
    for (int k = 0; k < BAR_COUNT; k++) begin
      r.band  = k[BAR_W-1:0];
      r.level = bar_height[k];
      r.last  = (k == BAR_COUNT - 1);
      bars_due.push_back(r);
    end
  endfunction

  function automatic void track_display(input spec_item_t it);
    int b;
    logic [LVL_W-1:0] lvl;
    if (it.action == ACT_FALL) begin
      for (b = 0; b < SBPH_BANDS; b++) begin
        if (frame_peak[b] < bar_height[b]) begin
          bar_height[b] = (bar_height[b] > fall_step_r) ? bar_height[b] - fall_step_r : '0;
        end
      end
      emit_bars();
    end else begin
      if (int'(it.idx) < SBPH_BINS / 2) begin
        b = (int'(it.idx) * 2 * SBPH_BANDS) / SBPH_BINS;
        if (b < SBPH_BANDS) begin
          lvl = bin_log_level(it.re, it.im, gain_r);
          if (lvl > band_peak_run[b]) band_peak_run[b] = lvl;
        end
      end
      if (it.last) begin
        for (b = 0; b < SBPH_BANDS; b++) begin
          frame_peak[b] = band_peak_run[b];
          band_peak_run[b] = '0;
          if (frame_peak[b] > bar_height[b]) bar_height[b] = frame_peak[b];
        end
        emit_bars();
      end
    end
  endfunction

  function automatic void put(input logic action, input logic [IDX_W-1:0] idx,
                              input logic [SMP_W-1:0] re, input logic [SMP_W-1:0] im,
                              input logic last);
    spec_item_t it;
    it.action = action;
    it.idx    = idx;
    it.re     = re;
    it.im     = im;
    it.last   = last;
    bins_to_send.push_back(it);
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    logic [SMP_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 32'h8000_0000;
      2: v = 32'h7FFF_FFFF;
      3, 4: v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(31, 8);
        if ($urandom_range(1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic void put_fall();
    put(ACT_FALL, IDX_W'($urandom), $urandom, $urandom, 1'($urandom));
  endfunction

  function automatic void queue_random(input int n, input int fall_pct);
    int count;
    int r;
    int len;
    logic [IDX_W-1:0] idx;
    count = 0;
    while (count < n) begin
      r = $urandom_range(99);
      if (r < fall_pct) begin
        put_fall();
        count++;
      end else if (r < fall_pct + 10) begin
        put(ACT_BIN, IDX_W'($urandom), pick_sample(), pick_sample(), 1'b0);
        count++;
      end else begin
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++) begin
          idx = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(SBPH_BINS / 2 - 1))
                                          : IDX_W'($urandom_range(SBPH_BINS - 1, SBPH_BINS / 2));
          put(ACT_BIN, idx, pick_sample(), pick_sample(), k == len - 1);
        end
        count += len;
      end
    end
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FALL_STEP:  fall_step_r = val;
      REG_LEVEL_GAIN: gain_r = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (bins_to_send.size() != 0 || in_valid || bars_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_display(on_wire);
      if (!in_valid || !in_stall) begin
        if (bins_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = bins_to_send.pop_front();
          in_valid     <= 1'b1;
          in_action    <= on_wire.action;
          in_bin_index <= on_wire.idx;
          in_bin_real  <= on_wire.re;
          in_bin_imag  <= on_wire.im;
          in_last_bin  <= on_wire.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!burst_on) begin
      burst_cycles <= 0;
    end else if (burst_cycles < BURST_LEN) begin
      burst_cycles <= burst_cycles + 1;
    end
  end

  assign hold_out = burst_on && (burst_cycles < BURST_LEN);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bars_due.size() == 0) begin
          $error("unexpected bar: band_number %0d bar_level %0d last_bar %0d",
                 out_band_number, out_bar_level, out_last_bar);
          mismatches++;
        end else begin
          want = bars_due.pop_front();
          if (out_band_number !== want.band) begin
            $error("band_number: expected %0d, actual %0d", want.band, out_band_number);
            mismatches++;
          end
          if (out_bar_level !== want.level) begin
            $error("bar_level: expected %0d, actual %0d", want.level, out_bar_level);
            mismatches++;
          end
          if (out_last_bar !== want.last) begin
            $error("last_bar: expected %0d, actual %0d", want.last, out_last_bar);
            mismatches++;
          end
        end
      end
      out_stall <= hold_out || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    fall_step_r = FALL_STEP_RST;
    gain_r = LEVEL_GAIN_RST;
    for (int k = 0; k < SBPH_BANDS; k++) begin
      band_peak_run[k] = '0;
      frame_peak[k] = '0;
      bar_height[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, band edges, upper half, fall floor
    put(ACT_FALL, '0, '0, '0, 1'b0);
    put(ACT_BIN, 9'd0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    put(ACT_BIN, 9'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
    put(ACT_BIN, 9'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    put(ACT_BIN, 9'd32, 32'h0001_0000, 32'h0000_0000, 1'b0);
    put(ACT_BIN, 9'd64, 32'h0001_0001, 32'h0000_0000, 1'b0);
    put(ACT_BIN, 9'd31, 32'hFFFF_0000, 32'h0000_0000, 1'b0);
    put(ACT_BIN, 9'd96, 32'h0000_0000, 32'h0014_0000, 1'b0);
    put(ACT_BIN, 9'd128, 32'h0000_8000, 32'h0000_8000, 1'b0);
    put(ACT_BIN, 9'd160, 32'h0003_0000, 32'hFFFC_0000, 1'b0);
    put(ACT_BIN, 9'd256, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    put(ACT_BIN, 9'd511, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    put(ACT_FALL, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    put(ACT_BIN, 9'd200, 32'h0000_0000, 32'h0000_0000, 1'b1);
    put(ACT_FALL, 9'd0, '0, '0, 1'b0);
    put(ACT_FALL, 9'd0, '0, '0, 1'b0);
    put(ACT_FALL, 9'd0, '0, '0, 1'b0);
    put(ACT_BIN, 9'd224, 32'h0000_0000, 32'h0100_0000, 1'b1);
    put(ACT_FALL, 9'd0, '0, '0, 1'b0);
    queue_random(35, 15);
    settle();

    set_reg(REG_FALL_STEP, 16'd32768);
    set_reg(REG_LEVEL_GAIN, 16'hFFFF);
    set_reg(REG_SPARE_A, CFG_W'($urandom));
    send_idle_pct <= 69;
    recv_stall_pct <= 0;
    queue_random(45, 20);
    settle();

    set_reg(REG_FALL_STEP, 16'd0);
    set_reg(REG_LEVEL_GAIN, 16'd0);
    send_idle_pct <= 0;
    recv_stall_pct <= 69;
    queue_random(15, 20);
    settle();
    set_reg(REG_FALL_STEP, 16'd1);
    set_reg(REG_LEVEL_GAIN, CFG_W'($urandom_range(65535, 1)));
    queue_random(20, 20);
    settle();

    set_reg(REG_FALL_STEP, CFG_W'($urandom_range(32768)));
    set_reg(REG_LEVEL_GAIN, CFG_W'($urandom));
    set_reg(REG_SPARE_B, CFG_W'($urandom));
    send_idle_pct <= 34;
    recv_stall_pct <= 34;
    queue_random(45, 20);
    settle();

    // hold the result side while items keep coming
    set_reg(REG_FALL_STEP, FALL_STEP_RST);
    set_reg(REG_LEVEL_GAIN, LEVEL_GAIN_RST);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    burst_on <= 1'b1;
    repeat (4) put_fall();
    queue_random(26, 30);
    settle();
    burst_on <= 1'b0;

    set_reg(REG_FALL_STEP, CFG_W'($urandom_range(32768)));
    set_reg(REG_LEVEL_GAIN, CFG_W'($urandom));
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(2))
        0: send_idle_pct <= 0;
        1: send_idle_pct <= 34;
        default: send_idle_pct <= 69;
      endcase
      case ($urandom_range(2))
        0: recv_stall_pct <= 0;
        1: recv_stall_pct <= 34;
        default: recv_stall_pct <= 69;
      endcase
      queue_random(12, 20);
      settle();
    end

    if (bars_due.size() != 0) begin
      $error("%0d bars never arrived", bars_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
